### src/crb_pkg.sv
// Shared types and constants of the clipped rectangle blitter.
// Depends on nothing; the core and the testbench import it.
package crb_pkg;

  // Default screen geometry
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 200;

  // Command codes
  typedef enum logic [2:0] {
    CMD_FILL   = 3'd0,
    CMD_OPAQUE = 3'd1,
    CMD_KEYED  = 3'd2,
    CMD_PIXEL  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_CLIPPED   = 2'd1,
    STAT_KEY_SKIP  = 2'd2,
    STAT_NOT_ARMED = 2'd3
  } status_t;

  // Armed blit mode
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_OPAQUE = 2'd1,
    MODE_KEYED  = 2'd2
  } mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_ADDR,
    FSM_FILL,
    FSM_WRITE,
    FSM_READ,
    FSM_RWAIT
  } fsm_t;

endpackage

### src/crb_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing; holds the frame store of the blitter.
module crb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64000
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### src/clipped_rect_blitter_core.sv
// Top level of the clipped rectangle blitter: command sequencer, clip logic,
// shared address unit and blit state. Depends on crb_pkg and crb_ram.
//
// Each command is taken when start is high and busy is low, and gives one
// result beat on done (with read_data, status, last) that must be taken in
// that cycle. A command ends in decode on a blit start, fully clipped or
// empty fill, clipped or skipped pixel, pixel with no blit armed, off-screen
// read or unknown command. A written source pixel goes on through address
// and write, an on-screen read through address, read and read wait, a fill
// through address and its clipped W by H pixels: the single frame memory
// port writes one pixel per cycle, and one shared unit forms each start
// address as row * SCREEN_WIDTH + column. busy is high from the cycle after
// a command is taken until its result beat; the next command may be given
// in the cycle of that beat. The frame store needs no clearing after reset.
module clipped_rect_blitter_core #(
  parameter int SCREEN_WIDTH  = crb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = crb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [12:0] rect_width,
  input  logic signed [12:0] rect_height,
  input  logic [7:0]         value,
  output logic               done,
  output logic [7:0]         read_data,
  output logic [1:0]         status,
  output logic               last
);
  import crb_pkg::*;

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);
  localparam int CW    = $clog2(SCREEN_WIDTH + 1);
  localparam int RW    = $clog2(SCREEN_HEIGHT + 1);
  localparam logic signed [17:0] W18 = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] H18 = 18'(SCREEN_HEIGHT);

  fsm_t state, state_next;

  // Latched command beat
  logic [2:0]         cmd_q;
  logic signed [15:0] pos_x_q, pos_y_q;
  logic signed [12:0] w_q, h_q;
  logic [7:0]         value_q;

  // Blit state
  mode_t              blit_mode;
  logic signed [15:0] origin_x, origin_y;
  logic [11:0]        bitmap_width, bitmap_height;
  logic [7:0]         key_byte;
  logic [11:0]        column_count, row_count;

  // Walk registers
  logic [XW-1:0] ax;
  logic [YW-1:0] ay;
  logic [CW-1:0] fill_w, col_idx;
  logic [RW-1:0] fill_h, row_idx;
  logic [AW-1:0] addr, row_addr, addr_calc;
  logic          pend_last;

  // Frame memory port
  logic       ram_en, ram_we;
  logic [7:0] ram_rdata;

  // Decode results
  logic          dec_fin, dec_last;
  status_t       dec_status;
  logic [XW-1:0] dec_ax;
  logic [YW-1:0] dec_ay;

  // Finish controls
  logic       fin, fin_last, fill_end, col_end, row_end;
  status_t    fin_status;
  logic [7:0] fin_data;

  assign busy = (state != FSM_IDLE);

  // Clip the fill rectangle on both axes
  logic signed [17:0] lo_x, hi_x, hic_x, span_x;
  logic signed [17:0] lo_y, hi_y, hic_y, span_y;
  logic               fill_empty;

  always_comb begin
    lo_x   = (pos_x_q < 0) ? 18'sd0 : 18'(pos_x_q);
    hi_x   = 18'(pos_x_q) + 18'(w_q);
    hic_x  = (hi_x > W18) ? W18 : hi_x;
    span_x = hic_x - lo_x;
    lo_y   = (pos_y_q < 0) ? 18'sd0 : 18'(pos_y_q);
    hi_y   = 18'(pos_y_q) + 18'(h_q);
    hic_y  = (hi_y > H18) ? H18 : hi_y;
    span_y = hic_y - lo_y;
    fill_empty = !(hic_x > lo_x) || !(hic_y > lo_y);
  end

  // Source pixel position and raster advance
  logic signed [16:0] pix_x, pix_y;
  logic               pix_on, key_hit, col_wrap, row_wrap, size_empty, rd_on;
  logic [12:0]        col_inc, row_inc;

  always_comb begin
    pix_x    = 17'(origin_x) + $signed(17'(column_count));
    pix_y    = 17'(origin_y) + $signed(17'(row_count));
    pix_on   = !pix_x[16] && (18'(pix_x) < W18) && !pix_y[16] && (18'(pix_y) < H18);
    key_hit  = (blit_mode == MODE_KEYED) && (value_q == key_byte);
    col_inc  = 13'(column_count) + 13'd1;
    row_inc  = 13'(row_count) + 13'd1;
    col_wrap = (col_inc >= 13'(bitmap_width));
    row_wrap = col_wrap && (row_inc >= 13'(bitmap_height));
    size_empty = w_q[12] || (w_q == 13'sd0) || h_q[12] || (h_q == 13'sd0);
    rd_on    = !pos_x_q[15] && (18'(pos_x_q) < W18) && !pos_y_q[15] && (18'(pos_y_q) < H18);
  end

  // Decide each command
  always_comb begin
    dec_fin    = 1'b1;
    dec_status = STAT_DONE;
    dec_last   = 1'b0;
    dec_ax     = '0;
    dec_ay     = '0;
    case (cmd_q)
      CMD_FILL: begin
        if (fill_empty) begin
          dec_status = STAT_CLIPPED;
        end else begin
          dec_fin = 1'b0;
          dec_ax  = lo_x[XW-1:0];
          dec_ay  = lo_y[YW-1:0];
        end
      end
      CMD_OPAQUE, CMD_KEYED: begin
        if (size_empty) dec_status = STAT_CLIPPED;
      end
      CMD_PIXEL: begin
        if (blit_mode == MODE_NONE) begin
          dec_status = STAT_NOT_ARMED;
        end else begin
          dec_last = row_wrap;
          if (!pix_on) begin
            dec_status = STAT_CLIPPED;
          end else if (key_hit) begin
            dec_status = STAT_KEY_SKIP;
          end else begin
            dec_fin = 1'b0;
            dec_ax  = pix_x[XW-1:0];
            dec_ay  = pix_y[YW-1:0];
          end
        end
      end
      CMD_READ: begin
        if (!rd_on) begin
          dec_status = STAT_CLIPPED;
        end else begin
          dec_fin = 1'b0;
          dec_ax  = pos_x_q[XW-1:0];
          dec_ay  = pos_y_q[YW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Shared address unit: row * width + column
  assign addr_calc = AW'(ay) * AW'(SCREEN_WIDTH) + AW'(ax);

  // Fill walk end of row and of rectangle
  assign col_end  = ((col_idx + CW'(1)) == fill_w);
  assign row_end  = ((row_idx + RW'(1)) == fill_h);
  assign fill_end = col_end && row_end;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE:   if (start) state_next = FSM_DECODE;
      FSM_DECODE: state_next = dec_fin ? FSM_IDLE : FSM_ADDR;
      FSM_ADDR: begin
        case (cmd_q)
          CMD_FILL:  state_next = FSM_FILL;
          CMD_PIXEL: state_next = FSM_WRITE;
          default:   state_next = FSM_READ;
        endcase
      end
      FSM_FILL:  if (fill_end) state_next = FSM_IDLE;
      FSM_WRITE: state_next = FSM_IDLE;
      FSM_READ:  state_next = FSM_RWAIT;
      FSM_RWAIT: state_next = FSM_IDLE;
      default:   state_next = FSM_IDLE;
    endcase
  end

  // Memory strobes and result beat
  always_comb begin
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    fin        = 1'b0;
    fin_status = STAT_DONE;
    fin_last   = 1'b0;
    fin_data   = '0;
    case (state)
      FSM_DECODE: begin
        fin        = dec_fin;
        fin_status = dec_status;
        fin_last   = dec_last;
      end
      FSM_FILL: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        fin    = fill_end;
      end
      FSM_WRITE: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        fin      = 1'b1;
        fin_last = pend_last;
      end
      FSM_READ: ram_en = 1'b1;
      FSM_RWAIT: begin
        fin      = 1'b1;
        fin_data = ram_rdata;
      end
      default: ;
    endcase
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FSM_IDLE;
      done          <= 1'b0;
      blit_mode     <= MODE_NONE;
      origin_x      <= '0;
      origin_y      <= '0;
      bitmap_width  <= '0;
      bitmap_height <= '0;
      key_byte      <= '0;
      column_count  <= '0;
      row_count     <= '0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == FSM_DECODE) begin
        // Arm or disarm on a blit start
        if (cmd_q == CMD_OPAQUE || cmd_q == CMD_KEYED) begin
          column_count <= '0;
          row_count    <= '0;
          if (size_empty) begin
            blit_mode <= MODE_NONE;
          end else begin
            blit_mode     <= (cmd_q == CMD_KEYED) ? MODE_KEYED : MODE_OPAQUE;
            origin_x      <= pos_x_q;
            origin_y      <= pos_y_q;
            bitmap_width  <= w_q[11:0];
            bitmap_height <= h_q[11:0];
            if (cmd_q == CMD_KEYED) key_byte <= value_q;
          end
        end
        // Advance the raster position on a source pixel
        if (cmd_q == CMD_PIXEL && blit_mode != MODE_NONE) begin
          if (col_wrap) begin
            column_count <= '0;
            if (row_wrap) begin
              row_count <= '0;
              blit_mode <= MODE_NONE;
            end else begin
              row_count <= row_inc[11:0];
            end
          end else begin
            column_count <= col_inc[11:0];
          end
        end
      end
    end
  end

  // Payload: command beat, walk registers, result fields
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q   <= cmd;
      pos_x_q <= pos_x;
      pos_y_q <= pos_y;
      w_q     <= rect_width;
      h_q     <= rect_height;
      value_q <= value;
    end
    if (state == FSM_DECODE) begin
      ax        <= dec_ax;
      ay        <= dec_ay;
      fill_w    <= span_x[CW-1:0];
      fill_h    <= span_y[RW-1:0];
      pend_last <= dec_last;
    end
    if (state == FSM_ADDR) begin
      addr     <= addr_calc;
      row_addr <= addr_calc;
      col_idx  <= '0;
      row_idx  <= '0;
    end
    // Step along the row, then drop to the next row
    if (state == FSM_FILL) begin
      if (col_end) begin
        col_idx  <= '0;
        row_idx  <= row_idx + RW'(1);
        row_addr <= row_addr + AW'(SCREEN_WIDTH);
        addr     <= row_addr + AW'(SCREEN_WIDTH);
      end else begin
        col_idx <= col_idx + CW'(1);
        addr    <= addr + AW'(1);
      end
    end
    if (fin) begin
      read_data <= fin_data;
      status    <= fin_status;
      last      <= fin_last;
    end
  end

  crb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (addr),
    .wdata (value_q),
    .rdata (ram_rdata)
  );

  // Every command that leaves the busy phase gives a result beat
  a_busy_ends_in_beat: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  // A result beat comes only once the sequencer is idle
  a_beat_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  // last marks only an armed source pixel
  a_last_on_pixel: assert property (@(posedge clk) disable iff (rst)
    done && last |-> (cmd_q == CMD_PIXEL) && (status != STAT_NOT_ARMED))
    else $error("last on a beat that is not an armed source pixel");

  // Read data is nonzero only for a read command
  a_data_on_read: assert property (@(posedge clk) disable iff (rst)
    done && (read_data != 8'd0) |-> (cmd_q == CMD_READ))
    else $error("read data on a beat that is not a read");

  // Memory accesses stay inside the frame
  a_addr_in_frame: assert property (@(posedge clk) disable iff (rst)
    ram_en |-> ((AW+1)'(addr) < (AW+1)'(DEPTH)))
    else $error("frame memory access beyond the screen");

endmodule

### tb/tb_clipped_rect_blitter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for clipped_rect_blitter_core: directed and random commands,
// with results predicted by a shadow copy of the frame store and blit state.
// Depends on crb_pkg and the blitter RTL.

import crb_pkg::*;

localparam int SCR_W = SCREEN_WIDTH_DEF;
localparam int SCR_H = SCREEN_HEIGHT_DEF;

// One expected result beat
typedef struct packed {
  logic [7:0] pixel;
  status_t    code;
  logic       tail;
} blit_beat_t;

// Shadow of the frame store and blit registers; predicts and checks result beats
class frame_shadow;
  logic [7:0]         frame [SCR_W*SCR_H];
  mode_t              mode;
  logic signed [15:0] org_x, org_y;
  logic [11:0]        span_w, span_h;
  logic [7:0]         key;
  logic [11:0]        col, row;
  blit_beat_t         beats_due[$];
  int                 errors;

  function new();
    mode   = MODE_NONE;
    org_x  = '0;
    org_y  = '0;
    span_w = '0;
    span_h = '0;
    key    = '0;
    col    = '0;
    row    = '0;
    errors = 0;
    foreach (frame[i]) frame[i] = 8'h00;
  endfunction

  function bit on_screen(int x, int y);
    return x >= 0 && x < SCR_W && y >= 0 && y < SCR_H;
  endfunction

  // Clip [origin, origin+len) to [0, limit); return kept length, first kept coordinate
  function int clip_span(int origin, int len, int limit, output int first);
    int lo, hi;
    lo = (origin < 0) ? 0 : origin;
    hi = origin + len;
    if (hi > limit) hi = limit;
    first = lo;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function int pending();
    return beats_due.size();
  endfunction

  // Apply one accepted command and queue the beat it must produce
  function void take_command(cmd_t op, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [12:0] w, logic signed [12:0] h, logic [7:0] val);
    blit_beat_t res;
    int cx, cy, cw, ch, px, py;
    res = '{pixel: 8'h00, code: STAT_DONE, tail: 1'b0};
    case (op)
      CMD_FILL: begin
        cw = clip_span(int'(x), int'(w), SCR_W, cx);
        ch = clip_span(int'(y), int'(h), SCR_H, cy);
        if (cw == 0 || ch == 0) begin
          res.code = STAT_CLIPPED;
        end else begin
          for (int r = 0; r < ch; r++)
            for (int c = 0; c < cw; c++)
              frame[(cy + r) * SCR_W + cx + c] = val;
        end
      end
      CMD_OPAQUE, CMD_KEYED: begin
        col = '0;
        row = '0;
        if (w <= 0 || h <= 0) begin
          mode     = MODE_NONE;
          res.code = STAT_CLIPPED;
        end else begin
          mode   = (op == CMD_KEYED) ? MODE_KEYED : MODE_OPAQUE;
          org_x  = x;
          org_y  = y;
          span_w = w[11:0];
          span_h = h[11:0];
          if (op == CMD_KEYED) key = val;
        end
      end
      CMD_PIXEL: begin
        if (mode == MODE_NONE) begin
          res.code = STAT_NOT_ARMED;
        end else begin
          px = int'(org_x) + int'(col);
          py = int'(org_y) + int'(row);
          if (!on_screen(px, py)) res.code = STAT_CLIPPED;
          else if (mode == MODE_KEYED && val == key) res.code = STAT_KEY_SKIP;
          else frame[py * SCR_W + px] = val;
          // advance the raster position, disarm after the final pixel
          col = col + 12'd1;
          if (col >= span_w) begin
            col = '0;
            row = row + 12'd1;
            if (row >= span_h) begin
              row      = '0;
              mode     = MODE_NONE;
              res.tail = 1'b1;
            end
          end
        end
      end
      CMD_READ: begin
        if (on_screen(int'(x), int'(y))) res.pixel = frame[int'(y) * SCR_W + int'(x)];
        else res.code = STAT_CLIPPED;
      end
      default: ;
    endcase
    beats_due.push_back(res);
  endfunction

  // Compare one result beat with the oldest prediction
  function void check_result(logic [7:0] rd, logic [1:0] st, logic lst);
    blit_beat_t want;
    if (beats_due.size() == 0) begin
      $error("result beat with no command outstanding: read_data=%0h status=%0d last=%0b",
             rd, st, lst);
      errors++;
      return;
    end
    want = beats_due.pop_front();
    if (rd !== want.pixel) begin
      $error("read_data: expected %0h, got %0h", want.pixel, rd);
      errors++;
    end
    if (st !== want.code) begin
      $error("status: expected %0d, got %0d", want.code, st);
      errors++;
    end
    if (lst !== want.tail) begin
      $error("last: expected %0b, got %0b", want.tail, lst);
      errors++;
    end
  endfunction
endclass

module tb_clipped_rect_blitter_core;
  localparam int QUIET_LIMIT  = 250000;
  localparam int SETTLE_TICKS = 16;
  localparam int RANDOM_ITEMS = 1900;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         cmd;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [12:0] rect_width;
  logic signed [12:0] rect_height;
  logic [7:0]         value;
  logic               done;
  logic [7:0]         read_data;
  logic [1:0]         status;
  logic               last;

  frame_shadow shadow;
  int          quiet_cycles = 0;
  bit          no_idle_run  = 1'b0;
  int          area_x, area_y, area_w, area_h;

  clipped_rect_blitter_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .value       (value),
    .done        (done),
    .read_data   (read_data),
    .status      (status),
    .last        (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check result beats, record accepted commands, watch for a stall
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) shadow.check_result(read_data, status, last);
      if (start && busy === 1'b0)
        shadow.take_command(cmd_t'(cmd), pos_x, pos_y, rect_width, rect_height, value);
      if (done === 1'b1 || (start && busy === 1'b0)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // Mostly short gaps, a few long ones, none during a no-idle run
  function int pick_gap();
    int r;
    if (no_idle_run) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return rand_between(1, 3);
    return rand_between(4, 40);
  endfunction

  task automatic hold_off(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one command beat, wait until it is taken, then idle a random gap
  task automatic send_cmd(cmd_t op, int x, int y, int w, int h, logic [7:0] val);
    start       <= 1'b1;
    cmd         <= op;
    pos_x       <= 16'(x);
    pos_y       <= 16'(y);
    rect_width  <= 13'(w);
    rect_height <= 13'(h);
    value       <= val;
    do @(posedge clk); while (busy !== 1'b0);
    hold_off(pick_gap());
  endtask

  // Hold the sender until every outstanding beat has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  task automatic fill_random();
    int r, x, y, w, h;
    r = $urandom_range(99);
    if (r < 60) begin
      x = rand_between(-8, SCR_W + 7);
      y = rand_between(-8, SCR_H + 7);
      w = rand_between(1, 16);
      h = rand_between(1, 16);
    end else if (r < 75) begin
      // empty size
      x = rand_between(-20, SCR_W);
      y = rand_between(-20, SCR_H);
      w = rand_between(-4096, 0);
      h = rand_between(-4096, 16);
      if ($urandom_range(1)) begin
        w = rand_between(1, 16);
        h = rand_between(-4096, 0);
      end
    end else if (r < 88) begin
      x = rand_between(-32768, 32767);
      y = rand_between(-32768, 32767);
      w = rand_between(-4096, 4095);
      h = rand_between(-4096, 4095);
    end else if ($urandom_range(1)) begin
      // wide strip, usually clipped on both sides
      x = rand_between(-4000, 0);
      w = 4095;
      y = rand_between(0, SCR_H - 1);
      h = rand_between(1, 2);
    end else begin
      x = rand_between(0, SCR_W - 1);
      w = rand_between(1, 2);
      y = rand_between(-4000, 0);
      h = 4095;
    end
    send_cmd(CMD_FILL, x, y, w, h, 8'($urandom));
  endtask

  task automatic read_random();
    int r, x, y;
    r = $urandom_range(99);
    if (r < 45) begin
      x = rand_between(0, SCR_W - 1);
      y = rand_between(0, SCR_H - 1);
    end else if (r < 85) begin
      // around the latest bitmap
      x = area_x + rand_between(-1, area_w);
      y = area_y + rand_between(-1, area_h);
    end else begin
      x = rand_between(-32768, 32767);
      y = rand_between(-32768, 32767);
    end
    send_cmd(CMD_READ, x, y, rand_between(-4096, 4095), rand_between(-4096, 4095),
             8'($urandom));
  endtask

  initial begin
    int   items, r, n;
    bit   keyed;
    logic [7:0] key, pix;

    shadow      = new();
    rst         <= 1'b1;
    start       <= 1'b0;
    cmd         <= CMD_FILL;
    pos_x       <= '0;
    pos_y       <= '0;
    rect_width  <= '0;
    rect_height <= '0;
    value       <= '0;
    area_x = 0;
    area_y = 0;
    area_w = 1;
    area_h = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: off-screen read and stray pixel before anything is written
    send_cmd(CMD_READ, -32768, 32767, 0, 0, 8'h00);
    send_cmd(CMD_PIXEL, 0, 0, 1, 1, 8'hFF);
    // cover the whole screen, so every later read hits a written pixel
    send_cmd(CMD_FILL, -10, -10, 4095, 4095, 8'h5A);
    // fully clipped and empty fills
    send_cmd(CMD_FILL, 32767, 0, 10, 10, 8'hFF);
    send_cmd(CMD_FILL, -32768, -32768, 4095, 4095, 8'h00);
    send_cmd(CMD_FILL, 5, 5, -4096, 3, 8'h33);
    send_cmd(CMD_FILL, 5, 5, 3, 0, 8'h33);
    // corner fill partly off screen, then read both sides of it
    send_cmd(CMD_FILL, SCR_W - 4, SCR_H - 4, 8, 8, 8'h11);
    send_cmd(CMD_READ, SCR_W - 1, SCR_H - 1, 0, 0, 8'h00);
    send_cmd(CMD_READ, 0, 0, 0, 0, 8'h00);
    send_cmd(CMD_READ, SCR_W, 0, 0, 0, 8'h00);
    // empty bitmap leaves nothing armed
    send_cmd(CMD_OPAQUE, 0, 0, 5, 0, 8'h00);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'h12);
    // opaque bitmap hanging off the bottom-right corner
    send_cmd(CMD_OPAQUE, SCR_W - 2, SCR_H - 1, 3, 2, 8'h00);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'h00);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'hFF);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'h80);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'h01);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'h7F);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'hFE);
    send_cmd(CMD_READ, SCR_W - 1, SCR_H - 1, 0, 0, 8'h00);
    // keyed: off-screen wins over a key match, then an on-screen key match
    send_cmd(CMD_KEYED, -1, 0, 2, 1, 8'h44);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'h44);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'h44);
    // a new start replaces an armed bitmap
    send_cmd(CMD_KEYED, 10, 10, 4, 4, 8'h00);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'h21);
    send_cmd(CMD_OPAQUE, -1, 0, 1, 1, 8'h00);
    send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'h99);
    drain_results();

    // Random: mostly complete bitmaps, plus fills, reads and broken sequences
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(99) == 0) no_idle_run = !no_idle_run;
      if ($urandom_range(199) == 0) drain_results();
      r = $urandom_range(99);
      if (r < 55) begin
        keyed  = $urandom_range(1);
        area_w = rand_between(1, 12);
        area_h = rand_between(1, 6);
        if ($urandom_range(9) == 0) begin
          area_x = rand_between(-32768, 32767);
          area_y = rand_between(-32768, 32767);
        end else begin
          area_x = rand_between(-6, SCR_W - 4);
          area_y = rand_between(-6, SCR_H - 3);
        end
        key = 8'($urandom);
        send_cmd(keyed ? CMD_KEYED : CMD_OPAQUE, area_x, area_y, area_w, area_h, key);
        items++;
        for (n = 0; n < area_w * area_h; n++) begin
          r = $urandom_range(99);
          // drop the rest of the bitmap; a later start replaces it
          if (r < 2) break;
          if (r < 4) begin
            fill_random();
            items++;
          end else if (r < 6) begin
            read_random();
            items++;
          end
          pix = (keyed && $urandom_range(2) == 0) ? key : 8'($urandom);
          send_cmd(CMD_PIXEL, rand_between(-32768, 32767), rand_between(-32768, 32767),
                   rand_between(-4096, 4095), rand_between(-4096, 4095), pix);
          items++;
        end
      end else if (r < 68) begin
        fill_random();
        items++;
      end else if (r < 82) begin
        read_random();
        items++;
      end else if (r < 90) begin
        // empty bitmap start
        send_cmd($urandom_range(1) ? CMD_KEYED : CMD_OPAQUE,
                 rand_between(-32768, 32767), rand_between(-32768, 32767),
                 rand_between(-4096, 0), rand_between(-4096, 4095), 8'($urandom));
        items++;
      end else if (r < 95) begin
        // stray pixels; answered with a not-armed status when nothing is armed
        repeat (rand_between(1, 3))
          send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'($urandom));
      end else begin
        // large bitmap armed and left unfinished
        area_x = rand_between(-64, SCR_W);
        area_y = rand_between(-64, SCR_H);
        area_w = rand_between(100, 4095);
        area_h = rand_between(1, 4095);
        send_cmd($urandom_range(1) ? CMD_KEYED : CMD_OPAQUE, area_x, area_y, area_w, area_h,
                 8'($urandom));
        items++;
        repeat (rand_between(1, 8)) begin
          send_cmd(CMD_PIXEL, 0, 0, 0, 0, 8'($urandom));
          items++;
        end
      end
    end

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

### sim.f
src/crb_pkg.sv
src/crb_ram.sv
src/clipped_rect_blitter_core.sv
tb/tb_clipped_rect_blitter_core.sv
